// ===== hdl/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 sequence decoder.
`default_nettype none

package u8d_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  count_t;
	typedef logic [20:0] cp_t;

	typedef struct packed {
		byte_t  byte0;
		byte_t  byte1;
		byte_t  byte2;
		byte_t  byte3;
		count_t bytes_available;
	} win_t;

	typedef struct packed {
		cp_t    code_point;
		count_t consumed;
	} res_t;

	localparam cp_t    REPLACEMENT_CP = 21'h00_fffd;
	localparam cp_t    MAX_CP         = 21'h10_ffff;
	localparam cp_t    SURR_LO        = 21'h00_d800;
	localparam cp_t    SURR_HI        = 21'h00_dfff;
	localparam cp_t    LEAST_TWO      = 21'h00_0080;
	localparam cp_t    LEAST_THREE    = 21'h00_0800;
	localparam cp_t    LEAST_FOUR     = 21'h01_0000;
	localparam count_t AVAIL_MAX      = 3'd4;
	localparam count_t CONSUMED_NONE  = 3'd0;
	localparam count_t CONSUMED_ONE   = 3'd1;

endpackage

`default_nettype wire

// ===== hdl/u8d_if.sv =====
// Valid/ready channels for input windows and decoded results.
`default_nettype none

interface u8d_win_if import u8d_pkg::*;;
	logic valid;
	logic ready;
	win_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface u8d_res_if import u8d_pkg::*;;
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/utf8_sequence_decoder.sv =====
// Top level of the UTF-8 sequence decoder: input register, decode, result register.
//
//  channel | dir | word                                          | accepted when
//  --------+-----+-----------------------------------------------+--------------------
//  win     | in  | byte0..byte3, bytes_available                 | win.valid & win.ready
//  res     | out | code_point, consumed                          | res.valid & res.ready
//
// A window passes through the input register and then the result register.
// A window is taken every cycle unless both stages hold data and the result is stalled.
// arst_n clears both stage valid bits; payload registers are not reset.
// A stalled result holds; each stage refills as soon as the one after it moves.
`default_nettype none

module utf8_sequence_decoder import u8d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	u8d_win_if.sink   win,
	u8d_res_if.source res
);

	logic valid_s1;
	logic valid_s2;
	win_t win_s1;
	res_t res_s2;
	res_t res_c;
	logic ready_s1;
	logic ready_s2;

	assign ready_s2  = !valid_s2 || res.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign win.ready = ready_s1;

	u8d_decode u_decode (
		.win (win_s1),
		.res (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= win.valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && win.valid) win_s1 <= win.data;
		if (ready_s2 && valid_s1) res_s2 <= res_c;
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	a_consumed_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.consumed <= AVAIL_MAX))
		else $error("consumed above four");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.data.consumed == CONSUMED_NONE)) |-> (res.data.code_point == '0))
		else $error("nonzero code point with nothing consumed");

	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.data.consumed != CONSUMED_NONE)) |->
		((res.data.code_point <= MAX_CP) &&
		 !((res.data.code_point >= SURR_LO) && (res.data.code_point <= SURR_HI))))
		else $error("code point not a scalar value");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> valid_s2)
		else $error("decoded word lost between stages");

endmodule

`default_nettype wire

// ===== hdl/u8d_decode.sv =====
// Combinational decode of one registered four-byte window.
`default_nettype none

module u8d_decode import u8d_pkg::*; (
	input  win_t win,
	output res_t res
);

	typedef enum logic [2:0] {
		LC_ASCII,
		LC_TWO,
		LC_THREE,
		LC_FOUR,
		LC_BAD
	} lead_class_t;

	lead_class_t cls;
	count_t      avail;
	count_t      len;
	cp_t         val;
	cp_t         least;
	logic        cont_ok;
	logic        c1, c2, c3;
	logic        surrogate;

	assign c1 = (win.byte1[7:6] == 2'b10);
	assign c2 = (win.byte2[7:6] == 2'b10);
	assign c3 = (win.byte3[7:6] == 2'b10);

	always_comb begin
		avail = (win.bytes_available > AVAIL_MAX) ? AVAIL_MAX : win.bytes_available;

		unique case (win.byte0) inside
			[8'h00:8'h7f]: cls = LC_ASCII;
			[8'hc2:8'hdf]: cls = LC_TWO;
			[8'he0:8'hef]: cls = LC_THREE;
			[8'hf0:8'hf4]: cls = LC_FOUR;
			default:       cls = LC_BAD;
		endcase

		unique case (cls)
			LC_TWO: begin
				len     = 3'd2;
				val     = {10'd0, win.byte0[4:0], win.byte1[5:0]};
				least   = LEAST_TWO;
				cont_ok = c1;
			end
			LC_THREE: begin
				len     = 3'd3;
				val     = {5'd0, win.byte0[3:0], win.byte1[5:0], win.byte2[5:0]};
				least   = LEAST_THREE;
				cont_ok = c1 & c2;
			end
			LC_FOUR: begin
				len     = 3'd4;
				val     = {win.byte0[2:0], win.byte1[5:0], win.byte2[5:0], win.byte3[5:0]};
				least   = LEAST_FOUR;
				cont_ok = c1 & c2 & c3;
			end
			default: begin
				len     = CONSUMED_ONE;
				val     = {13'd0, win.byte0};
				least   = '0;
				cont_ok = 1'b1;
			end
		endcase

		surrogate = (val >= SURR_LO) && (val <= SURR_HI);

		if (avail == CONSUMED_NONE) begin
			res = '{code_point: '0, consumed: CONSUMED_NONE};
		end else if (cls == LC_ASCII) begin
			res = '{code_point: {13'd0, win.byte0}, consumed: CONSUMED_ONE};
		end else if (cls == LC_BAD) begin
			res = '{code_point: REPLACEMENT_CP, consumed: CONSUMED_ONE};
		end else if (len > avail) begin
			res = '{code_point: '0, consumed: CONSUMED_NONE};
		end else if (!cont_ok) begin
			res = '{code_point: REPLACEMENT_CP, consumed: CONSUMED_ONE};
		end else if ((val < least) || surrogate || (val > MAX_CP)) begin
			res = '{code_point: REPLACEMENT_CP, consumed: len};
		end else begin
			res = '{code_point: val, consumed: len};
		end
	end

endmodule

`default_nettype wire
